FILE: rtl/core/u8dec_pkg.sv
// ----------------------------------------------------------------------------
// u8dec_pkg: shared types and constants for the UTF-8 code point decoder
// Holds field widths, byte-pattern constants and code point limits.
// ----------------------------------------------------------------------------
`default_nettype none

package u8dec_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned CP_W   = 21;
  localparam int unsigned LEN_W  = 3;

  typedef logic [BYTE_W-1:0] byte_t;
  typedef logic [CP_W-1:0]   cp_t;
  typedef logic [LEN_W-1:0]  len_t;

  // Lengths of a decoded sequence
  localparam len_t LEN_1 = 3'd1;
  localparam len_t LEN_2 = 3'd2;
  localparam len_t LEN_3 = 3'd3;
  localparam len_t LEN_4 = 3'd4;

  // Lead byte limits
  localparam byte_t LEAD2_MIN = 8'hC2;
  localparam byte_t LEAD4_MAX = 8'hF4;

  // Code point limits
  localparam cp_t CP3_MIN  = 21'h000800;
  localparam cp_t SURR_LO  = 21'h00D800;
  localparam cp_t SURR_HI  = 21'h00DFFF;
  localparam cp_t CP4_MIN  = 21'h010000;
  localparam cp_t CP4_MAX  = 21'h10FFFF;

  // Registered window of four bytes
  typedef struct packed {
    byte_t b0;
    byte_t b1;
    byte_t b2;
    byte_t b3;
  } window_t;

  // Decoded result word
  typedef struct packed {
    cp_t  cp;
    len_t len;
  } result_t;

endpackage : u8dec_pkg

`default_nettype wire

FILE: rtl/core/utf8_codepoint_decoder_unit.sv
// Latency: an accepted start passes the input register, then the result register, before out_valid.
// Throughput: one window per cycle; the input and result registers form a
// two-stage pipeline and busy is high only during reset, since the receiver
// cannot stall.
// Reset: synchronous, active low; clears the stage valid flags only.
// ----------------------------------------------------------------------------
// utf8_codepoint_decoder_unit: UTF-8 code point decoder, top level
// Registers a four-byte window, decodes it and registers the result word.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8_codepoint_decoder_unit (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    start,
  output logic                   busy,
  input  wire  u8dec_pkg::byte_t in_byte0,
  input  wire  u8dec_pkg::byte_t in_byte1,
  input  wire  u8dec_pkg::byte_t in_byte2,
  input  wire  u8dec_pkg::byte_t in_byte3,
  output logic                   out_valid,
  output u8dec_pkg::cp_t         out_code_point,
  output u8dec_pkg::len_t        out_consumed
);
  import u8dec_pkg::*;

  logic    in_vld_r, in_vld_nxt;
  logic    out_vld_r, out_vld_nxt;
  window_t win_r;
  result_t res_nxt, res_r;

  // Stall the input side only while reset is held
  assign busy        = !rst_n;
  assign in_vld_nxt  = start;
  assign out_vld_nxt = in_vld_r;

  // Advance the valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // Capture the window word
  always_ff @(posedge clk) begin
    if (start) begin
      win_r <= '{b0: in_byte0, b1: in_byte1, b2: in_byte2, b3: in_byte3};
    end
  end

  u8dec_logic u_logic (
    .win (win_r),
    .res (res_nxt)
  );

  // Hold the decoded word
  always_ff @(posedge clk) begin
    if (in_vld_r) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid      = out_vld_r;
  assign out_code_point = res_r.cp;
  assign out_consumed   = res_r.len;

  // A strobe follows every accepted word once it has passed both registers
  a_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> ##1 out_valid)
    else $error("result strobe missing");

  // Consumed count stays in one to four
  a_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_consumed >= LEN_1 && out_consumed <= LEN_4))
    else $error("consumed out of range");

  // Single-byte results carry the raw lead byte
  a_raw: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_consumed == LEN_1) |-> (out_code_point[CP_W-1:BYTE_W] == '0))
    else $error("fallback code point wider than a byte");

  // No result lands in the surrogate range or above the maximum
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_code_point <= CP4_MAX
                   && !(out_code_point >= SURR_LO && out_code_point <= SURR_HI)))
    else $error("code point out of range");

endmodule : utf8_codepoint_decoder_unit

`default_nettype wire

FILE: rtl/core/u8dec_logic.sv
// ----------------------------------------------------------------------------
// u8dec_logic: combinational UTF-8 decode of a four-byte window
// Classifies the lead byte, checks continuation bytes and range, and
// falls back to the raw lead byte with length one on any malformed form.
// ----------------------------------------------------------------------------
`default_nettype none

module u8dec_logic (
  input  wire  u8dec_pkg::window_t win,
  output u8dec_pkg::result_t       res
);
  import u8dec_pkg::*;

  logic c1, c2, c3;
  cp_t  v2, v3, v4;
  logic ok2, ok3, ok4;

  // Check continuation bytes
  assign c1 = (win.b1[7:6] == 2'b10);
  assign c2 = (win.b2[7:6] == 2'b10);
  assign c3 = (win.b3[7:6] == 2'b10);

  // Assemble candidate values
  assign v2 = {10'd0, win.b0[4:0], win.b1[5:0]};
  assign v3 = {5'd0, win.b0[3:0], win.b1[5:0], win.b2[5:0]};
  assign v4 = {win.b0[2:0], win.b1[5:0], win.b2[5:0], win.b3[5:0]};

  // Validate each form
  assign ok2 = (win.b0[7:5] == 3'b110) && (win.b0 >= LEAD2_MIN) && c1;
  assign ok3 = (win.b0[7:4] == 4'b1110) && c1 && c2 && (v3 >= CP3_MIN)
               && !((v3 >= SURR_LO) && (v3 <= SURR_HI));
  assign ok4 = (win.b0[7:3] == 5'b11110) && (win.b0 <= LEAD4_MAX)
               && c1 && c2 && c3 && (v4 >= CP4_MIN) && (v4 <= CP4_MAX);

  // Select result, raw lead byte on fallback
  always_comb begin
    if (ok2) begin
      res = '{cp: v2, len: LEN_2};
    end else if (ok3) begin
      res = '{cp: v3, len: LEN_3};
    end else if (ok4) begin
      res = '{cp: v4, len: LEN_4};
    end else begin
      res = '{cp: {13'd0, win.b0}, len: LEN_1};
    end
  end

endmodule : u8dec_logic

`default_nettype wire

FILE: dv/utf8_codepoint_decoder_checker.sv
// ----------------------------------------------------------------------------
// utf8_codepoint_decoder_checker: decode predictor and result comparator
// Watches the window and result ports of the decoder, works out the code
// point and byte count of every accepted window, and compares each result
// word with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module utf8_codepoint_decoder_checker (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic                   busy,
  input  u8dec_pkg::byte_t       in_byte0,
  input  u8dec_pkg::byte_t       in_byte1,
  input  u8dec_pkg::byte_t       in_byte2,
  input  u8dec_pkg::byte_t       in_byte3,
  input  logic                   out_valid,
  input  u8dec_pkg::cp_t         out_code_point,
  input  u8dec_pkg::len_t        out_consumed,
  output int                     fail_count,
  output int                     words_pending
);
  import u8dec_pkg::*;

  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    window_t win;
    result_t res;
  } decode_entry_t;

  decode_entry_t expected_decodes[$];
  int            mismatches = 0;

  // A continuation byte has the form 10xxxxxx
  function automatic logic is_tail(input byte_t b);
    return b[7:6] == 2'b10;
  endfunction

  // Decode one window; any malformed form falls back to the lead byte
  function automatic result_t decode_window(input window_t w);
    result_t r;
    cp_t     v;
    r.cp  = {13'b0, w.b0};
    r.len = LEN_1;
    if (w.b0[7:5] == 3'b110) begin
      if (w.b0 >= LEAD2_MIN && is_tail(w.b1)) begin
        r.cp  = {10'b0, w.b0[4:0], w.b1[5:0]};
        r.len = LEN_2;
      end
    end else if (w.b0[7:4] == 4'b1110) begin
      v = {5'b0, w.b0[3:0], w.b1[5:0], w.b2[5:0]};
      // reject overlong forms and surrogates
      if (is_tail(w.b1) && is_tail(w.b2) && v >= CP3_MIN &&
          !(v >= SURR_LO && v <= SURR_HI)) begin
        r.cp  = v;
        r.len = LEN_3;
      end
    end else if (w.b0[7:3] == 5'b11110) begin
      v = {w.b0[2:0], w.b1[5:0], w.b2[5:0], w.b3[5:0]};
      if (w.b0 <= LEAD4_MAX && is_tail(w.b1) && is_tail(w.b2) && is_tail(w.b3) &&
          v >= CP4_MIN && v <= CP4_MAX) begin
        r.cp  = v;
        r.len = LEN_4;
      end
    end
    return r;
  endfunction

  // Compare result words first, then record the window accepted at this edge
  always @(posedge clk) begin
    decode_entry_t e;
    window_t       w;
    if (rst_n) begin
      if (out_valid) begin
        if (expected_decodes.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display("unexpected result word: cp %h len %0d",
                     out_code_point, out_consumed);
        end else begin
          e = expected_decodes.pop_front();
          if (out_code_point !== e.res.cp || out_consumed !== e.res.len) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
              $display("decode mismatch for window %h: expected cp %h len %0d, got cp %h len %0d",
                       e.win, e.res.cp, e.res.len, out_code_point, out_consumed);
          end
        end
      end
      if (start && !busy) begin
        w       = '{b0: in_byte0, b1: in_byte1, b2: in_byte2, b3: in_byte3};
        e.win   = w;
        e.res   = decode_window(w);
        expected_decodes.push_back(e);
      end
    end
    fail_count    <= mismatches;
    words_pending <= expected_decodes.size();
  end

endmodule

FILE: dv/utf8_codepoint_decoder_unit_test.sv
// ----------------------------------------------------------------------------
// utf8_codepoint_decoder_unit_test: testbench top for the UTF-8 decoder
// Drives directed boundary windows and then mostly well-formed random
// sequences with broken and noisy ones mixed in, with random start gaps.
// A separate checker predicts and compares every result word.
// ----------------------------------------------------------------------------
module utf8_codepoint_decoder_unit_test;
  import u8dec_pkg::*;

  localparam int RANDOM_WORDS = 1250;
  localparam int STEADY_WORDS = 200;
  localparam int STALL_LIMIT  = 200;
  localparam int DRAIN_CYCLES = 4;

  logic  clk = 1'b0;
  logic  rst_n;
  logic  start;
  logic  busy;
  byte_t in_byte0, in_byte1, in_byte2, in_byte3;
  logic  out_valid;
  cp_t   out_code_point;
  len_t  out_consumed;
  int    fail_count;
  int    words_pending;
  logic  idle_on;

  utf8_codepoint_decoder_unit dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_byte0       (in_byte0),
    .in_byte1       (in_byte1),
    .in_byte2       (in_byte2),
    .in_byte3       (in_byte3),
    .out_valid      (out_valid),
    .out_code_point (out_code_point),
    .out_consumed   (out_consumed)
  );

  utf8_codepoint_decoder_checker checker_i (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_byte0       (in_byte0),
    .in_byte1       (in_byte1),
    .in_byte2       (in_byte2),
    .in_byte3       (in_byte3),
    .out_valid      (out_valid),
    .out_code_point (out_code_point),
    .out_consumed   (out_consumed),
    .fail_count     (fail_count),
    .words_pending  (words_pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 0;
  end

  // End the run when nothing moves on either channel for too long
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((start && !busy) || out_valid)
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("utf8_codepoint_decoder_unit_test failed");
    $finish;
  end

  // Present one window from a falling edge and hold it until accepted
  task automatic send_window(input window_t w);
    int gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 3);
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start    <= 1'b1;
    in_byte0 <= w.b0;
    in_byte1 <= w.b1;
    in_byte2 <= w.b2;
    in_byte3 <= w.b3;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
  endtask

  // Mostly well-formed sequences with random content; trailing bytes random
  function automatic window_t random_window();
    window_t w;
    int      kind;
    int      pos;
    logic [1:0] bad_top;
    w.b0 = 8'($urandom);
    w.b1 = 8'($urandom);
    w.b2 = 8'($urandom);
    w.b3 = 8'($urandom);
    kind = $urandom_range(0, 99);
    if (kind < 15) begin
      w.b0 = {1'b0, 7'($urandom)};
    end else if (kind < 35) begin
      w.b0 = {3'b110, 5'($urandom)};
      w.b1 = {2'b10, 6'($urandom)};
    end else if (kind < 60) begin
      w.b0 = {4'b1110, 4'($urandom)};
      // lean on the overlong and surrogate boundaries
      case ($urandom_range(0, 5))
        0: w.b0 = 8'hE0;
        1: w.b0 = 8'hED;
        default: ;
      endcase
      w.b1 = {2'b10, 6'($urandom)};
      w.b2 = {2'b10, 6'($urandom)};
    end else if (kind < 80) begin
      w.b0 = {5'b11110, 3'($urandom)};
      case ($urandom_range(0, 5))
        0: w.b0 = 8'hF0;
        1: w.b0 = 8'hF4;
        default: ;
      endcase
      w.b1 = {2'b10, 6'($urandom)};
      w.b2 = {2'b10, 6'($urandom)};
      w.b3 = {2'b10, 6'($urandom)};
    end else if (kind < 92) begin
      // multi-byte lead with one continuation byte broken
      w.b0 = {2'b11, 6'($urandom)};
      w.b1 = {2'b10, 6'($urandom)};
      w.b2 = {2'b10, 6'($urandom)};
      w.b3 = {2'b10, 6'($urandom)};
      pos  = $urandom_range(1, 3);
      bad_top = 2'($urandom_range(0, 2));
      if (bad_top == 2'b10) bad_top = 2'b11;
      case (pos)
        1: w.b1[7:6] = bad_top;
        2: w.b2[7:6] = bad_top;
        default: w.b3[7:6] = bad_top;
      endcase
    end
    return w;
  endfunction

  initial begin
    rst_n    = 1'b0;
    start    = 1'b0;
    in_byte0 = '0;
    in_byte1 = '0;
    in_byte2 = '0;
    in_byte3 = '0;
    idle_on  = 1'b1;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed windows: ASCII limits with junk after them
    send_window(32'h00000000);
    send_window(32'h7FFFFFFF);
    send_window(32'h41C3A9F0);
    // stray continuation and invalid leads
    send_window(32'h80808080);
    send_window(32'hBF808080);
    send_window(32'hF8808080);
    send_window(32'hFFFFFFFF);
    // two-byte forms: overlong leads, limits, bad continuation
    send_window(32'hC0800000);
    send_window(32'hC1BF0000);
    send_window(32'hC2800000);
    send_window(32'hDFBFFFFF);
    send_window(32'hC2410000);
    // three-byte forms: overlong, surrogate edges, limits, bad continuation
    send_window(32'hE09FBF00);
    send_window(32'hE0A08000);
    send_window(32'hED9FBF00);
    send_window(32'hEDA08000);
    send_window(32'hEDBFBF00);
    send_window(32'hEE808000);
    send_window(32'hEFBFBFFF);
    send_window(32'hE180C000);
    // four-byte forms: overlong, limits, above range, bad lead, bad continuation
    send_window(32'hF08FBFBF);
    send_window(32'hF0908080);
    send_window(32'hF48FBFBF);
    send_window(32'hF4908080);
    send_window(32'hF5808080);
    send_window(32'hF180807F);

    // Random windows; no start gaps in the last stretch
    for (int i = 0; i < RANDOM_WORDS; i++) begin
      if (i == RANDOM_WORDS - STEADY_WORDS) idle_on = 1'b0;
      send_window(random_window());
    end
    start <= 1'b0;

    // Drain outstanding result words, then let the pipeline settle
    while (words_pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0 && words_pending == 0)
      $display("utf8_codepoint_decoder_unit_test passed");
    else
      $display("utf8_codepoint_decoder_unit_test failed");
    $finish;
  end

endmodule
